// File: hw/rtl/tpf_pkg.sv
// tpf_pkg: shared types and constants for the tile pixel fetch block
// no dependencies; used by tile_pixel_fetch_core and the testbench

package tpf_pkg;

    // screen limits: a query at or past these reads as color 0
    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 192;

    // video memory: 16 KB split into four byte lanes by address bits 1:0
    localparam int VMEM_AW     = 14;
    localparam int BANK_COUNT  = 4;
    localparam int BANK_DEPTH  = 4096;
    localparam int BANK_AW     = 12;
    localparam int CMEM_DEPTH  = 32;
    localparam int CMEM_AW     = 5;

    // default depth of the result queue (power of two)
    localparam int OUT_DEPTH_DEF = 8;

    // request codes
    localparam logic [1:0] REQ_VWRITE = 2'd0;
    localparam logic [1:0] REQ_CWRITE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // one input beat as it travels the pipe
    typedef struct packed {
        logic [1:0]  req_type;
        logic [13:0] mem_address;
        logic [7:0]  write_data;
        logic [8:0]  pixel_x;
        logic [8:0]  pixel_y;
    } beat_t;

endpackage

// File: hw/rtl/tpf_ram.sv
// tpf_ram: generic single-write, dual-read memory with registered read data
// no dependencies; read during a write to the same address returns old data

module tpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [WIDTH-1:0]  rdata_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: hw/rtl/tile_pixel_fetch_core.sv
// tile_pixel_fetch_core: top level of the tile-map pixel lookup
// depends on tpf_pkg and tpf_ram (four video memory lanes)

// The block takes one beat per clock while in_stall is low: a byte write
// into the 16 KB video memory, a byte write into the 32-byte color memory,
// or a pixel query. A query reads the name-table entry, then the four
// pattern planes of the tile row, then looks up the color and pushes it
// into the result queue; results leave in query order. The pipe itself
// never stops: outside the clearing sweep, in_stall rises only when the
// result queue plus the queries still in flight reach OUT_DEPTH results
// (the queue holds them while out_stall is high), so with the default
// depth of 8 a sink that takes every result sustains one beat per cycle.
// After reset the video memory is zeroed by a sweep over all 4096 words,
// one word of all four byte lanes per cycle, during which in_stall is
// high; configuration writes are taken throughout.

module tile_pixel_fetch_core #(
    parameter int OUT_DEPTH = tpf_pkg::OUT_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_wr_data,
    // request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [13:0] mem_address,
    input  logic [7:0] write_data,
    input  logic [8:0] pixel_x,
    input  logic [8:0] pixel_y,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] pixel_color
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam int BAW   = tpf_pkg::BANK_AW;

    // name table base register
    logic [2:0] nts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nts_reg <= 3'd0;
        end
        else if (cfg_wr_en)
        begin
            nts_reg <= cfg_wr_data;
        end
    end

    // clearing sweep after reset
    logic           clearing_reg, clearing_next;
    logic [BAW-1:0] clear_cnt_reg, clear_cnt_next;

    always_comb
    begin
        clearing_next  = clearing_reg;
        clear_cnt_next = clear_cnt_reg;
        if (clearing_reg)
        begin
            clear_cnt_next = clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == {BAW{1'b1}})
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    // input handshake and result credit
    logic             in_accept;
    logic             q_accept;
    logic             out_pop;
    logic [CNT_W-1:0] credit_reg, credit_next;

    assign in_stall  = clearing_reg || (credit_reg == CNT_W'(OUT_DEPTH));
    assign in_accept = in_valid && !in_stall;
    assign q_accept  = in_accept && (req_type == tpf_pkg::REQ_QUERY);
    assign out_pop   = out_valid && !out_stall;

    assign credit_next = credit_reg + CNT_W'(q_accept) - CNT_W'(out_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    // pipe valid bits
    logic vld1_reg, vld2_reg, vld3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_accept;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // pipe payload
    tpf_pkg::beat_t beat0;
    tpf_pkg::beat_t beat1_reg, beat2_reg, beat3_reg;
    logic           off1;
    logic           off2_reg, off3_reg;
    logic           half2;
    logic           half3_reg;

    assign beat0 = '{req_type:    req_type,
                     mem_address: mem_address,
                     write_data:  write_data,
                     pixel_x:     pixel_x,
                     pixel_y:     pixel_y};

    always_ff @(posedge clk)
    begin
        beat1_reg <= beat0;
        beat2_reg <= beat1_reg;
        beat3_reg <= beat2_reg;
        off2_reg  <= off1;
        off3_reg  <= off2_reg;
        half3_reg <= half2;
    end

    // stage 1: screen check, name-table entry address, video writes
    logic [13:0]    entry_addr;
    logic           vwr1;
    logic [BAW-1:0] bank_waddr;
    logic [7:0]     bank_wdata;
    logic [3:0]     bank_we;

    assign off1 = (beat1_reg.pixel_x >= 9'(tpf_pkg::SCREEN_WIDTH))
               || (beat1_reg.pixel_y >= 9'(tpf_pkg::SCREEN_HEIGHT));

    assign entry_addr = 14'({nts_reg, 11'b0})
                      + 14'({beat1_reg.pixel_y[8:3], 6'b0})
                      + 14'({beat1_reg.pixel_x[8:3], 1'b0});

    assign vwr1       = vld1_reg && (beat1_reg.req_type == tpf_pkg::REQ_VWRITE);
    assign bank_waddr = clearing_reg ? clear_cnt_reg : beat1_reg.mem_address[13:2];
    assign bank_wdata = clearing_reg ? 8'd0 : beat1_reg.write_data;

    // stage 2: pick entry bytes, form pattern row address
    logic [7:0]     ent_data [tpf_pkg::BANK_COUNT];
    logic [7:0]     pat_data [tpf_pkg::BANK_COUNT];
    logic [7:0]     ent_lo, ent_hi;
    logic [8:0]     tile2;
    logic [BAW-1:0] pat_addr;

    // entry sits in lanes 0/1 or 2/3 depending on cell column bit 0
    assign ent_lo   = beat2_reg.pixel_x[3] ? ent_data[2] : ent_data[0];
    assign ent_hi   = beat2_reg.pixel_x[3] ? ent_data[3] : ent_data[1];
    assign tile2    = {ent_hi[0], ent_lo};
    assign half2    = ent_hi[3];
    assign pat_addr = {tile2, beat2_reg.pixel_y[2:0]};

    // four video memory lanes: port a for entries, port b for patterns
    for (genvar g = 0; g < tpf_pkg::BANK_COUNT; g++)
    begin : g_bank
        assign bank_we[g] = clearing_reg
                         || (vwr1 && (beat1_reg.mem_address[1:0] == 2'(g)));

        tpf_ram #(
            .WIDTH (8),
            .DEPTH (tpf_pkg::BANK_DEPTH)
        ) u_bank (
            .clk     (clk),
            .we      (bank_we[g]),
            .waddr   (bank_waddr),
            .wdata   (bank_wdata),
            .raddr_a (entry_addr[13:2]),
            .rdata_a (ent_data[g]),
            .raddr_b (pat_addr),
            .rdata_b (pat_data[g])
        );
    end

    // stage 3: plane bits, color lookup, color writes
    logic [2:0]  bit_sel;
    logic [3:0]  plane_idx;
    logic [4:0]  cidx;
    logic [7:0]  color3;
    logic        cwr3;
    logic        push3;
    logic [7:0]  cmem_reg [tpf_pkg::CMEM_DEPTH];

    // leftmost pixel is bit 7, so the bit is the inverted column
    assign bit_sel = ~beat3_reg.pixel_x[2:0];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            plane_idx[i] = pat_data[i][bit_sel];
        end
    end

    assign cidx   = {half3_reg, plane_idx};
    assign color3 = off3_reg ? 8'd0 : cmem_reg[cidx];
    assign cwr3   = vld3_reg && (beat3_reg.req_type == tpf_pkg::REQ_CWRITE);
    assign push3  = vld3_reg && (beat3_reg.req_type == tpf_pkg::REQ_QUERY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tpf_pkg::CMEM_DEPTH; i++)
            begin
                cmem_reg[i] <= 8'd0;
            end
        end
        else if (cwr3)
        begin
            cmem_reg[beat3_reg.mem_address[tpf_pkg::CMEM_AW-1:0]] <= beat3_reg.write_data;
        end
    end

    // result queue
    logic [7:0]   fifo_mem_reg [OUT_DEPTH];
    logic [PTR_W:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0] fifo_level;

    assign wr_ptr_next = wr_ptr_reg + (PTR_W+1)'(push3);
    assign rd_ptr_next = rd_ptr_reg + (PTR_W+1)'(out_pop);
    assign fifo_level  = wr_ptr_reg - rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push3)
        begin
            fifo_mem_reg[wr_ptr_reg[PTR_W-1:0]] <= color3;
        end
    end

    assign out_valid   = (wr_ptr_reg != rd_ptr_reg);
    assign pixel_color = fifo_mem_reg[rd_ptr_reg[PTR_W-1:0]];

    // checks
    logic [CNT_W-1:0] inflight;

    assign inflight = CNT_W'(vld1_reg && (beat1_reg.req_type == tpf_pkg::REQ_QUERY))
                    + CNT_W'(vld2_reg && (beat2_reg.req_type == tpf_pkg::REQ_QUERY))
                    + CNT_W'(push3)
                    + CNT_W'(fifo_level);

    // credit accounts for every query in the pipe and every queued result
    a_credit_match: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg == inflight)
        else $error("result credit out of step with queries in flight");

    // the queue never takes a beat while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push3 |-> (fifo_level < (PTR_W+1)'(OUT_DEPTH)))
        else $error("result queue overflow");

    // the clearing sweep ends only after the last word
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> ($past(clear_cnt_reg) == {BAW{1'b1}}))
        else $error("clearing sweep ended early");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for tile_pixel_fetch_core (tile-map pixel lookup)
// depends on tpf_pkg and the core rtl; predicts every pixel_color and checks it in order

import tpf_pkg::*;

// request code the block ignores
localparam logic [1:0] REQ_UNUSED = 2'd3;

class color_scoreboard;
    logic [7:0] video_mem [1 << VMEM_AW];
    logic [7:0] color_mem [CMEM_DEPTH];
    logic [2:0] name_base;
    logic [7:0] colors_due [$];
    int         errors;

    function new();
        foreach (video_mem[i]) video_mem[i] = 8'h00;
        foreach (color_mem[i]) color_mem[i] = 8'h00;
        name_base = 3'd0;
        errors = 0;
    endfunction

    function int pending();
        return colors_due.size();
    endfunction

    // color byte for one pixel, from the model memories
    function logic [7:0] predict_color(logic [8:0] x, logic [8:0] y);
        logic [13:0] entry_addr;
        logic [15:0] entry;
        logic [13:0] row_addr;
        logic [13:0] plane_addr;
        logic [2:0]  bit_pos;
        logic [3:0]  index;
        if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT)
            return 8'h00;
        // name-table entry of the 8x8 cell, little endian
        entry_addr = {name_base, 11'd0} + {2'b00, y[8:3], 6'd0} + {7'd0, x[8:3], 1'b0};
        entry = {video_mem[entry_addr + 14'd1], video_mem[entry_addr]};
        // four planes of the tile row, leftmost pixel in bit 7
        row_addr = {entry[8:0], 5'd0} + {9'd0, y[2:0], 2'd0};
        bit_pos = 3'd7 - x[2:0];
        for (int p = 0; p < 4; p++)
        begin
            plane_addr = row_addr + 14'(p);
            index[p] = video_mem[plane_addr][bit_pos];
        end
        return color_mem[{entry[11], index}];
    endfunction

    // update memories or queue the predicted color for an accepted beat
    function void accept_beat(beat_t b);
        case (b.req_type)
            REQ_VWRITE: video_mem[b.mem_address] = b.write_data;
            REQ_CWRITE: color_mem[b.mem_address[CMEM_AW-1:0]] = b.write_data;
            REQ_QUERY:  colors_due.push_back(predict_color(b.pixel_x, b.pixel_y));
            default: ;
        endcase
    endfunction

    task report(string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_color(logic [7:0] got);
        logic [7:0] want;
        if (colors_due.size() == 0)
        begin
            report($sformatf("pixel_color %02h with no query outstanding", got));
        end
        else
        begin
            want = colors_due.pop_front();
            if (got !== want)
                report($sformatf("pixel_color %02h, predicted %02h", got, want));
        end
    endtask
endclass

module tb;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 20000;
    localparam int PHASE_BEATS   = 270;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_wr_data = 3'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_VWRITE;
    logic [13:0] mem_address = 14'd0;
    logic [7:0]  write_data = 8'd0;
    logic [8:0]  pixel_x = 9'd0;
    logic [8:0]  pixel_y = 9'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  pixel_color;

    color_scoreboard sb = new();
    bit hold_req = 1'b0;
    bit calm = 1'b0;
    int beats_sent = 0;
    int quiet_cycles = 0;

    tile_pixel_fetch_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .mem_address (mem_address),
        .write_data  (write_data),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_color (pixel_color)
    );

    always #2 clk = ~clk;

    function automatic beat_t make_beat(logic [1:0] kind, logic [13:0] addr,
                                        logic [7:0] data, logic [8:0] x, logic [8:0] y);
        beat_t b;
        b.req_type    = kind;
        b.mem_address = addr;
        b.write_data  = data;
        b.pixel_x     = x;
        b.pixel_y     = y;
        return b;
    endfunction

    // offer one beat, with random idle cycles ahead of it outside the calm phase
    task automatic send_beat(input beat_t b);
        while (!calm && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= b.req_type;
        mem_address <= b.mem_address;
        write_data  <= b.write_data;
        pixel_x     <= b.pixel_x;
        pixel_y     <= b.pixel_y;
        do @(posedge clk); while (in_stall);
        sb.accept_beat(b);
        if (b.req_type != REQ_UNUSED)
            beats_sent++;
    endtask

    // stop offering and let every outstanding color and pending write finish
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_name_base(input logic [2:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.name_base = value;
    endtask

    // one cell set up end to end: entry, one pattern row, then pixels of that cell
    task automatic play_scene();
        int          cx;
        int          cy;
        int          row;
        int          tile;
        logic [13:0] entry_addr;
        logic [13:0] row_addr;
        logic [7:0]  entry_hi;
        cx = $urandom_range(31);
        cy = $urandom_range(23);
        row = $urandom_range(7);
        tile = $urandom_range(511);
        entry_addr = 14'({sb.name_base, 11'd0} + cy * 64 + cx * 2);
        entry_hi = 8'($urandom);
        entry_hi[0] = 1'(tile >> 8);
        send_beat(make_beat(REQ_VWRITE, entry_addr, 8'(tile), 9'($urandom), 9'($urandom)));
        send_beat(make_beat(REQ_VWRITE, entry_addr + 14'd1, entry_hi,
                            9'($urandom), 9'($urandom)));
        row_addr = 14'(tile * 32 + row * 4);
        for (int p = 0; p < 4; p++)
            send_beat(make_beat(REQ_VWRITE, row_addr + 14'(p), 8'($urandom),
                                9'($urandom), 9'($urandom)));
        if ($urandom_range(1) == 1)
            send_beat(make_beat(REQ_CWRITE, 14'($urandom), 8'($urandom),
                                9'($urandom), 9'($urandom)));
        repeat ($urandom_range(6, 2))
            send_beat(make_beat(REQ_QUERY, 14'($urandom), 8'($urandom),
                                9'(cx * 8 + $urandom_range(7)),
                                9'(cy * 8 + ($urandom_range(4) == 0 ?
                                             $urandom_range(7) : row))));
    endtask

    // mostly well-formed scenes, the rest fully random beats
    task automatic random_step();
        if ($urandom_range(99) < 75)
            play_scene();
        else
            send_beat(make_beat(2'($urandom_range(3)), 14'($urandom), 8'($urandom),
                                9'($urandom), 9'($urandom)));
    endtask

    // result sink: random stalls, or one long hold when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < 18);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_color(pixel_color);
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    // stimulus
    initial
    begin
        int nts_plan [6];
        int phase_mid;
        int phase_end;
        nts_plan = '{7, 3, 0, 5, 0, 0};
        nts_plan[4] = $urandom_range(7);
        nts_plan[5] = $urandom_range(7);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_name_base(3'd0);

        // directed: memory extremes, both palette halves, screen edges, unused code
        send_beat(make_beat(REQ_CWRITE, 14'h3FE0, 8'hA5, 9'd0, 9'd0));
        send_beat(make_beat(REQ_CWRITE, 14'h3FFF, 8'h5A, 9'h1FF, 9'h1FF));
        send_beat(make_beat(REQ_CWRITE, 14'h0010, 8'h3C, 9'd0, 9'd0));
        send_beat(make_beat(REQ_CWRITE, 14'h000F, 8'hC3, 9'd0, 9'd0));
        send_beat(make_beat(REQ_VWRITE, 14'h0000, 8'hFF, 9'd0, 9'd0));
        send_beat(make_beat(REQ_VWRITE, 14'h0001, 8'h09, 9'd0, 9'd0));
        send_beat(make_beat(REQ_VWRITE, 14'h3FE0, 8'h80, 9'd0, 9'd0));
        send_beat(make_beat(REQ_VWRITE, 14'h3FE1, 8'h80, 9'd0, 9'd0));
        send_beat(make_beat(REQ_VWRITE, 14'h3FE2, 8'h80, 9'd0, 9'd0));
        send_beat(make_beat(REQ_VWRITE, 14'h3FE3, 8'h80, 9'd0, 9'd0));
        send_beat(make_beat(REQ_VWRITE, 14'h3FFF, 8'hFF, 9'd0, 9'd0));
        send_beat(make_beat(REQ_QUERY, 14'h0000, 8'h00, 9'd0, 9'd0));
        send_beat(make_beat(REQ_QUERY, 14'h0000, 8'h00, 9'd1, 9'd0));
        send_beat(make_beat(REQ_QUERY, 14'h0000, 8'h00, 9'd7, 9'd7));
        send_beat(make_beat(REQ_QUERY, 14'h3FFF, 8'hFF, 9'd255, 9'd191));
        send_beat(make_beat(REQ_QUERY, 14'h0000, 8'h00, 9'd256, 9'd0));
        send_beat(make_beat(REQ_QUERY, 14'h0000, 8'h00, 9'd0, 9'd192));
        send_beat(make_beat(REQ_QUERY, 14'h3FFF, 8'hFF, 9'h1FF, 9'h1FF));
        send_beat(make_beat(REQ_UNUSED, 14'h3FFF, 8'hFF, 9'h1FF, 9'h1FF));
        send_beat(make_beat(REQ_QUERY, 14'h0000, 8'h00, 9'd255, 9'd0));
        wait_drained();

        // random phases, each after writing its name table base from the plan
        for (int p = 0; p < 6; p++)
        begin
            write_name_base(3'(nts_plan[p]));
            calm = (p == 2);
            phase_mid = beats_sent + PHASE_BEATS / 2;
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_mid)
                random_step();
            // sink holds off while queries keep coming, so the input backs up
            if (p == 1)
            begin
                hold_req = 1'b1;
                repeat (40)
                    send_beat(make_beat(REQ_QUERY, 14'($urandom), 8'($urandom),
                                        9'($urandom_range(255)),
                                        9'($urandom_range(191))));
            end
            if (p == 3)
                wait_drained();
            while (beats_sent < phase_end)
                random_step();
            wait_drained();
        end
        calm = 1'b0;

        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
